// ----- rtl/wrs_pkg.sv -----
package wrs_pkg;

    localparam int unsigned WORD_WIDTH  = 64;
    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned FRAME_DEPTH = 64;

    localparam int unsigned ADDR_W    = $clog2(STORE_DEPTH);
    localparam int unsigned BASE_W    = $clog2(STORE_DEPTH + 1);
    localparam int unsigned SUM_W     = BASE_W + 1;
    localparam int unsigned TOP_W     = 9;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned SP_ADDR_W = $clog2(FRAME_DEPTH);
    localparam int unsigned CNT_W     = $clog2(FRAME_DEPTH + 1);

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_MOVE   = 3'd2,
        CMD_OPEN   = 3'd3,
        CMD_RETURN = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_RANGE       = 3'd1,
        ST_STORE_FULL  = 3'd2,
        ST_STACK_FULL  = 3'd3,
        ST_STACK_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_MOVE,
        S_RET
    } state_t;

    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [WORD_WIDTH-1:0] wdata;
    } word_port_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [SP_ADDR_W-1:0] addr;
        logic [TOP_W-1:0]     wdata;
    } size_port_t;

endpackage

// ----- rtl/windowed_register_stack_unit.sv -----
// Register file kept as a stack of call frames in one word store. Commands come
// in as one word each on the slave stream and each gives exactly one result word
// on the master stream, carrying the read data, a status code and the frame size
// after the command. Set, open frame, clear frame, unused codes, a move onto
// itself and every command that fails its checks load their result at once;
// get, move between distinct registers and return frame go through a second
// state that waits on the registered read of the word store (get, move) or of
// the saved-size stack (return). A new command is taken only in the idle state
// and when the output register is empty or is being read in the same cycle.
// Neither memory is cleared after reset, so the block is ready at once;
// registers are only readable once written inside the live frame.
module windowed_register_stack_unit
    import wrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // index[7:0], from_index[15:8], value[79:16]
    input  logic [CMD_W-1:0]      s_tuser,  // cmd[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // read_value[63:0], status[66:64],
                                            // frame_size[75:67], zero[79:76]
);

    word_port_t            word_port;
    size_port_t            size_port;
    logic [WORD_WIDTH-1:0] word_rdata;
    logic [TOP_W-1:0]      size_rdata;

    wrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .word_port  (word_port),
        .word_rdata (word_rdata),
        .size_port  (size_port),
        .size_rdata (size_rdata)
    );

    wrs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_word_store (
        .clk   (clk),
        .en    (word_port.en),
        .we    (word_port.we),
        .addr  (word_port.addr),
        .wdata (word_port.wdata),
        .rdata (word_rdata)
    );

    wrs_ram #(
        .WIDTH (TOP_W),
        .DEPTH (FRAME_DEPTH)
    ) u_size_stack (
        .clk   (clk),
        .en    (size_port.en),
        .we    (size_port.we),
        .addr  (size_port.addr),
        .wdata (size_port.wdata),
        .rdata (size_rdata)
    );

endmodule

// ----- rtl/wrs_ram.sv -----
module wrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- rtl/wrs_ctrl.sv -----
module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output word_port_t            word_port,
    input  logic [WORD_WIDTH-1:0] word_rdata,
    output size_port_t            size_port,
    input  logic [TOP_W-1:0]      size_rdata
);

    state_t                state_reg, state_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [TOP_W-1:0]      top_reg, top_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                  accept;
    cmd_t                  cmd;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      from_idx;
    logic [VALUE_W-1:0]    value;

    logic [SUM_W-1:0]      idx_sum, from_sum, top_sum, held_sum;
    logic                  store_full;
    logic                  grows, held_grows;
    logic [CNT_W-1:0]      count_dec;

    logic                  out_load;
    logic [VALUE_W-1:0]    out_rd;
    status_t               out_status;
    logic [TOP_W-1:0]      out_size;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cmd      = cmd_t'(s_tuser);
    assign idx      = s_tdata[7:0];
    assign from_idx = s_tdata[15:8];
    assign value    = s_tdata[79:16];

    // base + offset never passes STORE_DEPTH on a live access, so no wrap is needed
    assign idx_sum  = SUM_W'(base_reg) + SUM_W'(idx);
    assign from_sum = SUM_W'(base_reg) + SUM_W'(from_idx);
    assign top_sum  = SUM_W'(base_reg) + SUM_W'(top_reg);
    assign held_sum = SUM_W'(base_reg) + SUM_W'(idx_reg);

    assign store_full = top_sum >= SUM_W'(STORE_DEPTH);
    assign grows      = TOP_W'(idx) == top_reg;
    assign held_grows = TOP_W'(idx_reg) == top_reg;
    assign count_dec  = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_GET:
                        begin
                            if (TOP_W'(idx) < top_reg)
                            begin
                                state_next = S_GET;
                            end
                        end
                        CMD_MOVE:
                        begin
                            if (TOP_W'(idx) <= top_reg && TOP_W'(from_idx) < top_reg
                                && idx != from_idx && !(grows && store_full))
                            begin
                                state_next = S_MOVE;
                            end
                        end
                        CMD_RETURN:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_RET;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GET, S_MOVE, S_RET:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        base_next       = base_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        word_port.en    = 1'b0;
        word_port.we    = 1'b0;
        word_port.addr  = idx_sum[ADDR_W-1:0];
        word_port.wdata = value[WORD_WIDTH-1:0];
        size_port.en    = 1'b0;
        size_port.we    = 1'b0;
        size_port.addr  = count_reg[SP_ADDR_W-1:0];
        size_port.wdata = top_reg;
        out_load        = 1'b0;
        out_rd          = '0;
        out_status      = ST_OK;
        out_size        = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_SET:
                        begin
                            out_load = 1'b1;
                            if (TOP_W'(idx) > top_reg)
                            begin
                                out_status = ST_RANGE;
                            end
                            else if (grows && store_full)
                            begin
                                out_status = ST_STORE_FULL;
                            end
                            else
                            begin
                                word_port.en = 1'b1;
                                word_port.we = 1'b1;
                                if (grows)
                                begin
                                    top_next = top_reg + TOP_W'(1);
                                    out_size = top_reg + TOP_W'(1);
                                end
                            end
                        end
                        CMD_GET:
                        begin
                            if (TOP_W'(idx) < top_reg)
                            begin
                                word_port.en = 1'b1;
                            end
                            else
                            begin
                                out_load   = 1'b1;
                                out_status = ST_RANGE;
                            end
                        end
                        CMD_MOVE:
                        begin
                            idx_next       = idx;
                            word_port.addr = from_sum[ADDR_W-1:0];
                            if (TOP_W'(idx) > top_reg || TOP_W'(from_idx) >= top_reg)
                            begin
                                out_load   = 1'b1;
                                out_status = ST_RANGE;
                            end
                            else if (idx == from_idx)
                            begin
                                out_load = 1'b1;
                            end
                            else if (grows && store_full)
                            begin
                                out_load   = 1'b1;
                                out_status = ST_STORE_FULL;
                            end
                            else
                            begin
                                word_port.en = 1'b1;
                            end
                        end
                        CMD_OPEN:
                        begin
                            out_load = 1'b1;
                            if (count_reg >= CNT_W'(FRAME_DEPTH))
                            begin
                                out_status = ST_STACK_FULL;
                            end
                            else
                            begin
                                size_port.en = 1'b1;
                                size_port.we = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                base_next    = top_sum[BASE_W-1:0];
                                top_next     = '0;
                                out_size     = '0;
                            end
                        end
                        CMD_RETURN:
                        begin
                            size_port.addr = count_dec[SP_ADDR_W-1:0];
                            if (count_reg == '0)
                            begin
                                out_load   = 1'b1;
                                out_status = ST_STACK_EMPTY;
                            end
                            else
                            begin
                                size_port.en = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            out_load = 1'b1;
                            top_next = '0;
                            out_size = '0;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                out_load = 1'b1;
                out_rd   = VALUE_W'(word_rdata);
            end
            S_MOVE:
            begin
                out_load        = 1'b1;
                word_port.en    = 1'b1;
                word_port.we    = 1'b1;
                word_port.addr  = held_sum[ADDR_W-1:0];
                word_port.wdata = word_rdata;
                if (held_grows)
                begin
                    top_next = top_reg + TOP_W'(1);
                    out_size = top_reg + TOP_W'(1);
                end
            end
            S_RET:
            begin
                out_load   = 1'b1;
                count_next = count_dec;
                top_next   = size_rdata;
                out_size   = size_rdata;
                if (base_reg >= BASE_W'(size_rdata))
                begin
                    base_next = base_reg - BASE_W'(size_rdata);
                end
                else
                begin
                    base_next = '0;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // output word: read_value, status, frame_size from the low bit up
    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, out_size, out_status, out_rd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            top_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            top_reg      <= top_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- verif/wrs_frame_checker.sv -----
module wrs_frame_checker
    import wrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int unsigned           mismatches,
    output int unsigned           outstanding
);

    localparam int unsigned EXP_DEPTH = 16;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] read_value;
        logic [STATUS_W-1:0]   status;
        logic [TOP_W-1:0]      frame_size;
    } frame_result_t;

    logic [WORD_WIDTH-1:0] regs [STORE_DEPTH];
    logic [TOP_W-1:0]      saved_tops [FRAME_DEPTH];
    logic [BASE_W-1:0]     base;
    logic [TOP_W-1:0]      top;
    logic [CNT_W-1:0]      depth;
    frame_result_t         expected_results [EXP_DEPTH];
    int unsigned           exp_head;
    int unsigned           exp_count;

    // writing one past the top grows the frame, unless the store is used up
    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [WORD_WIDTH-1:0] w,
                                  output status_t st);
        st = ST_OK;
        if (TOP_W'(idx) == top) begin
            if (int'(base) + int'(top) >= int'(STORE_DEPTH)) begin
                st = ST_STORE_FULL;
                return;
            end
            top = top + 1'b1;
        end
        regs[(int'(base) + int'(idx)) % STORE_DEPTH] = w;
    endtask

    task automatic run_command(input logic [CMD_W-1:0] cmd,
                               input logic [IDX_W-1:0] idx,
                               input logic [IDX_W-1:0] from,
                               input logic [VALUE_W-1:0] value,
                               output frame_result_t r);
        status_t st;
        st = ST_OK;
        r.read_value = '0;
        case (cmd)
            CMD_SET:
                if (TOP_W'(idx) > top)
                    st = ST_RANGE;
                else
                    write_register(idx, value[WORD_WIDTH-1:0], st);
            CMD_GET:
                if (TOP_W'(idx) >= top)
                    st = ST_RANGE;
                else
                    r.read_value = regs[(int'(base) + int'(idx)) % STORE_DEPTH];
            CMD_MOVE:
                // target is checked before source
                if (TOP_W'(idx) > top || TOP_W'(from) >= top)
                    st = ST_RANGE;
                else if (idx != from)
                    write_register(idx, regs[(int'(base) + int'(from)) % STORE_DEPTH], st);
            CMD_OPEN:
                if (int'(depth) >= int'(FRAME_DEPTH)) begin
                    st = ST_STACK_FULL;
                end else begin
                    saved_tops[depth] = top;
                    depth = depth + 1'b1;
                    base = base + BASE_W'(top);
                    top = '0;
                end
            CMD_RETURN:
                if (depth == '0) begin
                    st = ST_STACK_EMPTY;
                end else begin
                    depth = depth - 1'b1;
                    top = saved_tops[depth];
                    base = (base >= BASE_W'(top)) ? base - BASE_W'(top) : '0;
                end
            CMD_CLEAR:
                top = '0;
            default: ;
        endcase
        r.status = st;
        r.frame_size = top;
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        frame_result_t want;
        frame_result_t got;
        if (!rst_n) begin
            base = '0;
            top = '0;
            depth = '0;
            exp_head = 0;
            exp_count = 0;
            outstanding = 0;
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                run_command(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[79:16], want);
                if (exp_count == EXP_DEPTH) begin
                    $error("too many result words pending: %0d", exp_count);
                    mismatches++;
                end else begin
                    expected_results[(exp_head + exp_count) % EXP_DEPTH] = want;
                    exp_count++;
                end
            end
            if (m_tvalid && m_tready) begin
                got.read_value = m_tdata[63:0];
                got.status = m_tdata[66:64];
                got.frame_size = m_tdata[75:67];
                if (exp_count == 0) begin
                    $error("result word with no command pending: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results[exp_head];
                    exp_head = (exp_head + 1) % EXP_DEPTH;
                    exp_count--;
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.frame_size !== want.frame_size) begin
                        $error("frame_size: expected %0d, got %0d",
                               want.frame_size, got.frame_size);
                        mismatches++;
                    end
                end
            end
            outstanding = exp_count;
        end
    end

endmodule

// ----- verif/windowed_register_stack_unit_tb.sv -----
module windowed_register_stack_unit_tb;
    import wrs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int SMALL_FRAME = 48;
    localparam int MAX_NEST = 10;
    localparam int MIX_WORDS = 25;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    int unsigned           mismatches;
    int unsigned           outstanding;

    int burst_left = 0;
    int ready_left = 0;
    int ready_kind = 0;
    int idle_cycles = 0;
    // rough view of the frame state, only used to aim the stimulus
    int guess_top = 0;
    int guess_saved [FRAME_DEPTH];
    int guess_depth = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    windowed_register_stack_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wrs_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: phases of always ready, random ready, and solid stalls
    always @(posedge clk) begin
        if (ready_left == 0) begin
            ready_kind = $urandom_range(0, 2);
            ready_left = (ready_kind == 0) ? $urandom_range(10, 80) :
                         (ready_kind == 1) ? $urandom_range(10, 40) : $urandom_range(1, 20);
        end
        ready_left--;
        case (ready_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= 1'b0;
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] some_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic issue(input logic [CMD_W-1:0] cmd, input int idx, input int from,
                         input logic [VALUE_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {word, from[7:0], idx[7:0]};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        burst_left--;
        case (cmd)
            CMD_SET:
                if (idx == guess_top)
                    guess_top++;
            CMD_MOVE:
                if (idx == guess_top && from < guess_top)
                    guess_top++;
            CMD_OPEN:
                if (guess_depth < FRAME_DEPTH) begin
                    guess_saved[guess_depth] = guess_top;
                    guess_depth++;
                    guess_top = 0;
                end
            CMD_RETURN:
                if (guess_depth > 0) begin
                    guess_depth--;
                    guess_top = guess_saved[guess_depth];
                end
            CMD_CLEAR:
                guess_top = 0;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // unwind every saved frame (the extra return hits the empty stack), then clear
    task automatic reach_bottom();
        repeat (guess_depth + 1) issue(CMD_RETURN, $urandom_range(0, 255),
                                       $urandom_range(0, 255), some_word());
        issue(CMD_CLEAR, 0, 0, some_word());
    endtask

    task automatic random_mix(input int count);
        int n;
        int r;
        int k;
        int idx;
        int from;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                k = $urandom_range(1, 8);
                repeat (k) begin
                    if (guess_top < SMALL_FRAME)
                        idx = guess_top;
                    else
                        idx = $urandom_range(0, guess_top - 1);
                    issue(CMD_SET, idx, $urandom_range(0, 255), some_word());
                    n++;
                end
            end else begin
                if (r < 48) begin
                    idx = (guess_top > 0) ? $urandom_range(0, guess_top - 1) : $urandom_range(0, 255);
                    issue(CMD_GET, idx, $urandom_range(0, 255), some_word());
                end else if (r < 56) begin
                    idx = (guess_top > 0) ? $urandom_range(0, guess_top - 1) : 0;
                    issue(CMD_SET, idx, $urandom_range(0, 255), some_word());
                end else if (r < 66) begin
                    idx = $urandom_range(0, (guess_top > 255) ? 255 : guess_top);
                    from = (guess_top > 0) ? $urandom_range(0, guess_top - 1) : $urandom_range(0, 255);
                    if ($urandom_range(0, 5) == 0)
                        from = idx;
                    issue(CMD_MOVE, idx, from, some_word());
                end else if (r < 73) begin
                    issue((guess_depth < MAX_NEST) ? CMD_OPEN : CMD_RETURN,
                          $urandom_range(0, 255), $urandom_range(0, 255), some_word());
                end else if (r < 82) begin
                    issue(CMD_RETURN, $urandom_range(0, 255), $urandom_range(0, 255), some_word());
                end else if (r < 85) begin
                    issue(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), some_word());
                end else begin
                    issue(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 255),
                          $urandom_range(0, 255), some_word());
                end
                n++;
            end
        end
    endtask

    // 64 nested frames, one more open overflows, then unwind past the bottom
    task automatic deep_calls();
        reach_bottom();
        issue(CMD_SET, 0, 0, some_word());
        repeat (FRAME_DEPTH + 1) begin
            issue(CMD_OPEN, 0, 0, some_word());
            if ($urandom_range(0, 7) == 0)
                issue(CMD_SET, 0, 0, some_word());
        end
        repeat (FRAME_DEPTH + 1) begin
            issue(CMD_RETURN, 0, 0, some_word());
            if ($urandom_range(0, 7) == 0)
                issue(CMD_GET, 0, 0, some_word());
        end
    endtask

    // frames of 256, 256, 256, 1 and 255 use up the whole store
    task automatic fill_store();
        int f;
        int i;
        int size;
        reach_bottom();
        for (f = 0; f < 5; f++) begin
            size = (f < 3) ? 256 : ((f == 3) ? 1 : 255);
            for (i = 0; i < size; i++) begin
                issue(CMD_SET, i, $urandom_range(0, 255), some_word());
                if ($urandom_range(0, 63) == 0)
                    issue(CMD_GET, $urandom_range(0, i), $urandom_range(0, 255), some_word());
            end
            if (f == 0) begin
                issue(CMD_SET, 255, 0, some_word());
                issue(CMD_GET, 255, 0, some_word());
                issue(CMD_MOVE, 0, 255, some_word());
            end
            if (f < 4)
                issue(CMD_OPEN, 0, 0, some_word());
        end
        issue(CMD_SET, 255, 0, some_word());
        issue(CMD_MOVE, 255, 0, some_word());
        issue(CMD_SET, 10, 0, some_word());
        issue(CMD_GET, 10, 0, some_word());
        issue(CMD_OPEN, 0, 0, some_word());
        issue(CMD_SET, 0, 0, some_word());
        issue(CMD_MOVE, 0, 0, some_word());
        issue(CMD_GET, 0, 0, some_word());
        issue(CMD_RETURN, 0, 0, some_word());
        reach_bottom();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_GET, 0, 0, '0);
        issue(CMD_RETURN, 0, 0, '0);
        issue(CMD_MOVE, 0, 0, '0);
        issue(CMD_SET, 1, 0, '1);
        issue(CMD_SET, 0, 0, '1);
        issue(CMD_SET, 1, 0, '0);
        issue(CMD_SET, 2, 0, 64'h5555_5555_5555_5555);
        issue(CMD_MOVE, 3, 0, '0);
        issue(CMD_MOVE, 1, 1, '0);
        issue(CMD_MOVE, 6, 0, '0);
        issue(CMD_MOVE, 2, 200, '0);
        issue(CMD_GET, 3, 0, '0);
        issue(CMD_GET, 4, 0, '0);
        issue(CMD_OPEN, 0, 0, '0);
        issue(CMD_GET, 0, 0, '0);
        issue(CMD_SET, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(CMD_MOVE, 1, 0, '0);
        issue(CMD_CLEAR, 0, 0, '0);
        issue(CMD_SET, 0, 0, 64'h0123_4567_89AB_CDEF);
        issue(CMD_RETURN, 0, 0, '0);
        issue(CMD_GET, 2, 0, '0);
        issue(CMD_SPARE_LO, 255, 255, '1);
        issue(CMD_SPARE_HI, 255, 255, '1);
        issue(CMD_SET, 255, 255, '1);
        issue(CMD_CLEAR, 0, 0, '0);
        drain();

        random_mix(MIX_WORDS);
        deep_calls();
        random_mix(MIX_WORDS);
        drain();
        fill_store();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
